// ===== sv/dts_pkg.sv =====
// Shared types, constants and sequence tables for the DDS tuner latch sequencer.
// No dependencies; every other file of the block refers to this package.
package dts_pkg;

	localparam int unsigned CfgIdxW  = 1;
	localparam int unsigned CfgDataW = 29;
	localparam int unsigned XtalW    = 29;
	localparam int unsigned PllW     = 5;
	localparam int unsigned FreqW    = 26;
	localparam int unsigned StepW    = 16;
	localparam int unsigned DenW     = XtalW + PllW;
	localparam int unsigned NumW     = FreqW + 16;
	localparam int unsigned RemW     = DenW + 1;
	localparam int unsigned QrW      = NumW + 1;
	localparam int unsigned ProdW    = StepW + PllW;
	localparam int unsigned WrW      = 6;
	localparam int unsigned DivCntW  = 6;
	localparam int unsigned DivSteps = NumW;

	localparam logic [XtalW-1:0] XtalReset = 29'd200000000;
	localparam logic [PllW-1:0]  PllReset  = 5'd1;
	localparam logic [FreqW-1:0] FreqMax   = 26'd65000000;
	localparam logic [StepW-1:0] StepMax   = 16'hffff;

	// band edges, inclusive
	localparam logic [FreqW-1:0] BandEdge0 = 26'd2250000;
	localparam logic [FreqW-1:0] BandEdge1 = 26'd5500000;
	localparam logic [FreqW-1:0] BandEdge2 = 26'd11000000;
	localparam logic [FreqW-1:0] BandEdge3 = 26'd22000000;
	localparam logic [FreqW-1:0] BandEdge4 = 26'd37500000;

	localparam logic [7:0] WrbBit      = 8'h40;
	localparam logic [7:0] DdsResetBit = 8'h80;
	localparam logic [7:0] BandMask    = 8'h3f;
	localparam logic [7:0] FullMask    = 8'hff;
	localparam logic [7:0] PttBit      = 8'h40;
	localparam logic [7:0] PreampBit   = 8'h80;
	localparam logic [7:0] TuneBase    = 8'h04;
	localparam logic [7:0] DdsMid      = 8'h80;
	localparam logic [11:0] DacMult    = 12'd4095;

	localparam logic [WrW-1:0] RstPre      = 6'd6;
	localparam logic [WrW-1:0] TuneLastWr  = 6'd24;
	localparam logic [WrW-1:0] RstLastWr   = 6'd33;

	typedef enum logic [1:0] {
		CMD_TUNE   = 2'd0,
		CMD_PTT    = 2'd1,
		CMD_PREAMP = 2'd2,
		CMD_RESET  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		LATCH_EXT      = 2'd0,
		LATCH_BAND     = 2'd1,
		LATCH_DDS_DATA = 2'd2,
		LATCH_DDS_CTRL = 2'd3
	} latch_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_XTAL = 1'd0,
		CFG_PLL  = 1'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROUND,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic round;
		logic decide;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_tune;
		logic div_last;
		logic out_free;
		logic emit_last;
	} ctl_sts_t;

	typedef struct packed {
		latch_t     sel;
		logic [7:0] value;
		logic [7:0] mask;
	} wr_t;

	// one-hot band relay code
	function automatic logic [7:0] band_value(input logic [FreqW-1:0] f);
		logic [7:0] v;
		if (f <= BandEdge0) begin
			v = 8'h01;
		end else if (f <= BandEdge1) begin
			v = 8'h02;
		end else if (f <= BandEdge2) begin
			v = 8'h08;
		end else if (f <= BandEdge3) begin
			v = 8'h04;
		end else if (f <= BandEdge4) begin
			v = 8'h10;
		end else begin
			v = 8'h20;
		end
		return v;
	endfunction

	// one of the four latch writes of a DDS register write
	function automatic wr_t dds_phase(input logic [7:0] addr, input logic [7:0] data,
			input logic [1:0] ph);
		wr_t w;
		w.mask = FullMask;
		case (ph)
			2'd0: begin
				w.sel = LATCH_DDS_DATA;
				w.value = data;
			end
			2'd1: begin
				w.sel = LATCH_DDS_CTRL;
				w.value = WrbBit | addr;
			end
			2'd2: begin
				w.sel = LATCH_DDS_CTRL;
				w.value = addr;
			end
			default: begin
				w.sel = LATCH_DDS_CTRL;
				w.value = WrbBit;
			end
		endcase
		return w;
	endfunction

	// start-up writes before the DDS register block
	function automatic wr_t rst_pre(input logic [2:0] idx);
		wr_t w;
		w.mask = FullMask;
		w.value = 8'h00;
		case (idx)
			3'd0: w.sel = LATCH_BAND;
			3'd1: w.sel = LATCH_DDS_CTRL;
			3'd2: w.sel = LATCH_DDS_DATA;
			3'd3: w.sel = LATCH_EXT;
			3'd4: begin
				w.sel = LATCH_DDS_CTRL;
				w.value = DdsResetBit | WrbBit;
			end
			default: begin
				w.sel = LATCH_DDS_CTRL;
				w.value = WrbBit;
			end
		endcase
		return w;
	endfunction

	function automatic logic [7:0] rst_addr(input logic [2:0] r);
		logic [7:0] a;
		case (r)
			3'd0: a = 8'h1d;
			3'd1: a = 8'h1e;
			3'd2: a = 8'h20;
			3'd3: a = 8'h21;
			3'd4: a = 8'h22;
			3'd5: a = 8'h23;
			default: a = 8'h24;
		endcase
		return a;
	endfunction

	function automatic logic [7:0] rst_data(input logic [2:0] r);
		logic [7:0] d;
		case (r)
			3'd0: d = 8'h10;
			3'd1: d = 8'h20;
			3'd2: d = 8'h60;
			3'd3: d = {4'h0, DacMult[11:8]};
			3'd4: d = DacMult[7:0];
			3'd5: d = {4'h0, DacMult[11:8]};
			default: d = DacMult[7:0];
		endcase
		return d;
	endfunction

endpackage

// ===== sv/dts_if.sv =====
// Valid/ready stream interfaces for the command and latch-write channels.
// Depends on dts_pkg for field widths.
interface dts_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                cmd;
	logic [dts_pkg::FreqW-1:0] freq_hz;
	logic                      switch_on;

	modport source(output valid, output cmd, output freq_hz, output switch_on, input ready);
	modport sink(input valid, input cmd, input freq_hz, input switch_on, output ready);
endinterface

interface dts_out_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                latch_select;
	logic [7:0]                latch_value;
	logic                      last;
	logic [dts_pkg::StepW-1:0] tuned_steps;
	logic                      tuned_valid;

	modport source(output valid, output latch_select, output latch_value, output last,
		output tuned_steps, output tuned_valid, input ready);
	modport sink(input valid, input latch_select, input latch_value, input last,
		input tuned_steps, input tuned_valid, output ready);
endinterface

// ===== sv/dts_ctrl.sv =====
// Controller state machine of the latch sequencer.
// Depends on dts_pkg for state, command and status types.
module dts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dts_pkg::ctl_sts_t sts,
	output dts_pkg::ctl_cmd_t ctl
);

	dts_pkg::state_t state_q;
	dts_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dts_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.in_tune ? dts_pkg::ST_DIV : dts_pkg::ST_EMIT;
				end
			end
			dts_pkg::ST_DIV: begin
				if (sts.div_last) begin
					state_d = dts_pkg::ST_ROUND;
				end
			end
			dts_pkg::ST_ROUND:  state_d = dts_pkg::ST_DECIDE;
			dts_pkg::ST_DECIDE: state_d = dts_pkg::ST_EMIT;
			dts_pkg::ST_EMIT: begin
				if (sts.out_free && sts.emit_last) begin
					state_d = dts_pkg::ST_IDLE;
				end
			end
			default: state_d = dts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ctl = '0;
		case (state_q)
			dts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			dts_pkg::ST_DIV:    ctl.div_step = 1'b1;
			dts_pkg::ST_ROUND:  ctl.round = 1'b1;
			dts_pkg::ST_DECIDE: ctl.decide = 1'b1;
			dts_pkg::ST_EMIT:   ctl.emit = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== sv/dts_datapath.sv =====
// Datapath: config registers, restoring divider, rounding, write sequencing,
// latch shadows and the output register. Depends on dts_pkg.
module dts_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dts_pkg::ctl_cmd_t            ctl,
	output dts_pkg::ctl_sts_t            sts,
	input  logic                         cfg_we,
	input  logic [dts_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dts_pkg::CfgDataW-1:0] cfg_data,
	input  logic [1:0]                   cmd,
	input  logic [dts_pkg::FreqW-1:0]    freq_hz,
	input  logic                         switch_on,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   latch_select,
	output logic [7:0]                   latch_value,
	output logic                         last,
	output logic [dts_pkg::StepW-1:0]    tuned_steps,
	output logic                         tuned_valid
);

	logic [dts_pkg::XtalW-1:0]   xtal_q;
	logic [dts_pkg::PllW-1:0]    pll_q;
	logic                        tuned_flag_q;
	logic [dts_pkg::StepW-1:0]   tuned_step_q;

	dts_pkg::cmd_t               cmd_q;
	logic [dts_pkg::FreqW-1:0]   freq_q;
	logic                        sw_q;
	logic [dts_pkg::DenW-1:0]    den_q;
	logic [dts_pkg::NumW-1:0]    num_q;     // numerator in, quotient out
	logic [dts_pkg::RemW-1:0]    rem_q;
	logic [dts_pkg::DivCntW-1:0] cnt_q;
	logic [dts_pkg::StepW-1:0]   k_q;
	logic [7:0]                  band_q;
	logic                        need_dds_q;
	logic [dts_pkg::ProdW-1:0]   prod_q;
	logic [dts_pkg::WrW-1:0]     wr_q;
	logic [7:0]                  shadow_q [4];

	logic                        out_valid_q;
	logic [1:0]                  sel_q;
	logic [7:0]                  value_q;
	logic                        last_q;
	logic [dts_pkg::StepW-1:0]   steps_q;
	logic                        tvalid_q;

	logic [dts_pkg::FreqW-1:0]   freq_clamp;
	logic [dts_pkg::RemW-1:0]    rem_sh;
	logic [dts_pkg::RemW-1:0]    den_ext;
	logic                        rem_ge;
	logic [dts_pkg::RemW:0]      twice_r;
	logic                        rnd_inc;
	logic [dts_pkg::QrW-1:0]     q_rnd;
	logic [dts_pkg::StepW-1:0]   k_next;
	logic [4:0]                  tj;
	logic [4:0]                  rj;
	logic [7:0]                  tune_data;
	dts_pkg::wr_t                cur;
	logic                        cur_last;
	logic [7:0]                  sh_cur;
	logic [7:0]                  sh_new;

	// configuration; any write drops the tuned mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_q <= dts_pkg::XtalReset;
			pll_q <= dts_pkg::PllReset;
		end else if (cfg_we) begin
			case (dts_pkg::cfg_idx_t'(cfg_index))
				dts_pkg::CFG_XTAL: xtal_q <= cfg_data[dts_pkg::XtalW-1:0];
				dts_pkg::CFG_PLL:  pll_q <= cfg_data[dts_pkg::PllW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuned_flag_q <= 1'b0;
			tuned_step_q <= '0;
		end else if (cfg_we) begin
			tuned_flag_q <= 1'b0;
		end else if (ctl.decide) begin
			tuned_flag_q <= 1'b1;
			tuned_step_q <= k_q;
		end
	end

	assign freq_clamp = (freq_hz > dts_pkg::FreqMax) ? dts_pkg::FreqMax : freq_hz;

	// restoring division, one quotient bit a cycle
	assign den_ext = dts_pkg::RemW'(den_q);
	assign rem_sh  = {rem_q[dts_pkg::RemW-2:0], num_q[dts_pkg::NumW-1]};
	assign rem_ge  = rem_sh >= den_ext;

	// round half to even, then saturate
	assign twice_r = {rem_q, 1'b0};
	assign rnd_inc = (twice_r > (dts_pkg::RemW+1)'(den_q))
		|| ((twice_r == (dts_pkg::RemW+1)'(den_q)) && num_q[0]);
	assign q_rnd   = {1'b0, num_q} + dts_pkg::QrW'(rnd_inc);
	assign k_next  = ((den_q == '0) || (q_rnd > dts_pkg::QrW'(dts_pkg::StepMax)))
		? dts_pkg::StepMax : q_rnd[dts_pkg::StepW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= dts_pkg::cmd_t'(cmd);
			freq_q <= freq_clamp;
			sw_q <= switch_on;
			den_q <= dts_pkg::DenW'(xtal_q) * dts_pkg::DenW'(pll_q);
			num_q <= {freq_clamp, 16'h0000};
			rem_q <= '0;
			cnt_q <= '0;
		end else if (ctl.div_step) begin
			rem_q <= rem_ge ? (rem_sh - den_ext) : rem_sh;
			num_q <= {num_q[dts_pkg::NumW-2:0], rem_ge};
			cnt_q <= cnt_q + dts_pkg::DivCntW'(1);
		end
		if (ctl.round) begin
			k_q <= k_next;
			band_q <= dts_pkg::band_value(freq_q);
		end
		if (ctl.decide) begin
			need_dds_q <= !tuned_flag_q || (k_q != tuned_step_q);
			prod_q <= dts_pkg::ProdW'(k_q) * dts_pkg::ProdW'(pll_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
		end else if (ctl.load) begin
			wr_q <= '0;
		end else if (ctl.emit) begin
			wr_q <= wr_q + dts_pkg::WrW'(1);
		end
	end

	// write list position within the DDS register block
	assign tj = 5'(wr_q - dts_pkg::WrW'(1));
	assign rj = 5'(wr_q - dts_pkg::RstPre);

	always_comb begin
		case (tj[4:2])
			3'd0:    tune_data = prod_q[15:8];
			3'd1:    tune_data = prod_q[7:0];
			3'd2:    tune_data = dts_pkg::DdsMid;
			default: tune_data = 8'h00;
		endcase
	end

	always_comb begin
		cur.sel = dts_pkg::LATCH_EXT;
		cur.value = 8'h00;
		cur.mask = dts_pkg::FullMask;
		cur_last = 1'b1;
		case (cmd_q)
			dts_pkg::CMD_TUNE: begin
				if (wr_q == '0) begin
					cur.sel = dts_pkg::LATCH_BAND;
					cur.value = band_q;
					cur.mask = dts_pkg::BandMask;
					cur_last = !need_dds_q;
				end else begin
					cur = dts_pkg::dds_phase(dts_pkg::TuneBase + {5'b00000, tj[4:2]},
						tune_data, tj[1:0]);
					cur_last = wr_q == dts_pkg::TuneLastWr;
				end
			end
			dts_pkg::CMD_PTT: begin
				cur.sel = dts_pkg::LATCH_BAND;
				cur.value = {1'b0, sw_q, 6'b000000};
				cur.mask = dts_pkg::PttBit;
			end
			dts_pkg::CMD_PREAMP: begin
				cur.sel = dts_pkg::LATCH_EXT;
				cur.value = {sw_q, 7'b0000000};
				cur.mask = dts_pkg::PreampBit;
			end
			dts_pkg::CMD_RESET: begin
				if (wr_q < dts_pkg::RstPre) begin
					cur = dts_pkg::rst_pre(wr_q[2:0]);
				end else begin
					cur = dts_pkg::dds_phase(dts_pkg::rst_addr(rj[4:2]),
						dts_pkg::rst_data(rj[4:2]), rj[1:0]);
				end
				cur_last = wr_q == dts_pkg::RstLastWr;
			end
			default: ;
		endcase
	end

	assign sh_cur = shadow_q[cur.sel];
	assign sh_new = (sh_cur & ~cur.mask) | (cur.value & cur.mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q <= '{default: 8'h00};
		end else if (ctl.emit) begin
			shadow_q[cur.sel] <= sh_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			sel_q <= cur.sel;
			value_q <= sh_new;
			last_q <= cur_last;
			steps_q <= tuned_step_q;
			tvalid_q <= tuned_flag_q;
		end
	end

	assign sts.in_tune   = dts_pkg::cmd_t'(cmd) == dts_pkg::CMD_TUNE;
	assign sts.div_last  = cnt_q == dts_pkg::DivCntW'(dts_pkg::DivSteps - 1);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.emit_last = cur_last;

	assign out_valid    = out_valid_q;
	assign latch_select = sel_q;
	assign latch_value  = value_q;
	assign last         = last_q;
	assign tuned_steps  = steps_q;
	assign tuned_valid  = tvalid_q;

`ifndef SYNTHESIS
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || out_ready))
		else $error("write loaded into an occupied output register");

	a_tuned_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tuned_flag_q) |-> $past(ctl.decide))
		else $error("tuned mark set outside the decide step");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && cur_last) |=> !ctl.emit)
		else $error("write issued after the final write of an item");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_step |-> (cnt_q < dts_pkg::DivCntW'(dts_pkg::DivSteps)))
		else $error("divider stepped past its last quotient bit");
`endif

endmodule

// ===== sv/dds_tuner_latch_sequencer.sv =====
// Top level of the DDS tuner latch sequencer.
// Depends on dts_pkg, dts_if, dts_ctrl and dts_datapath.
//
// Takes command items on cmds (tune, PTT bit, preamp bit, start-up sequence)
// and produces latch-write items on writes: latch select, full masked byte,
// a last flag on the final write of a command, and the tuned step count and
// tuned mark as they stand after the command.
// Config: cfg_we/cfg_index/cfg_data, index 0 xtal_hz, index 1 PLL multiplier;
// any write clears the tuned mark. Write only while no command is in flight.
// Sequence, one command at a time (ready only when idle):
//   PTT / preamp: accept, then a single write.
//   start-up sequence: 34 writes, one a cycle while writes.ready allows.
//   tune: restoring divide (one quotient bit per cycle of
//   freq*65536 / (xtal*pll)), a round and a decide step, then 1 or 25
//   writes.
// Writes leave through a single output register, so the next command is
// accepted while the final write still waits to be taken.
// Stall: when writes.ready is low the write sequence simply holds.
// Reset: config returns to 200 MHz / x1, latch shadows and tuned state clear;
// no writes are produced until a command item arrives.
module dds_tuner_latch_sequencer (
	input logic                         clk,
	input logic                         arst_n,
	dts_in_if.sink                      cmds,
	dts_out_if.source                   writes,
	input logic                         cfg_we,
	input logic [dts_pkg::CfgIdxW-1:0]  cfg_index,
	input logic [dts_pkg::CfgDataW-1:0] cfg_data
);

	dts_pkg::ctl_cmd_t ctl;
	dts_pkg::ctl_sts_t sts;

	// sequencing: idle, divide, round, decide, write out
	dts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmds.valid),
		.in_ready (cmds.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// arithmetic, shadows and the output register
	dts_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmds.cmd),
		.freq_hz      (cmds.freq_hz),
		.switch_on    (cmds.switch_on),
		.out_valid    (writes.valid),
		.out_ready    (writes.ready),
		.latch_select (writes.latch_select),
		.latch_value  (writes.latch_value),
		.last         (writes.last),
		.tuned_steps  (writes.tuned_steps),
		.tuned_valid  (writes.tuned_valid)
	);

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the DDS tuner latch sequencer.
// Depends on dts_pkg and the dts_in_if / dts_out_if interfaces from the RTL.
// Includes an item-level predictor of the latch writes for each command item.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no item moving on either channel before the run is abandoned
	localparam int StuckLimit = 1500;

	// start-up DDS register block, entry i in byte i
	localparam logic [55:0] InitAddr = {8'h24, 8'h23, 8'h22, 8'h21, 8'h20, 8'h1e, 8'h1d};
	localparam logic [55:0] InitData = {8'hff, 8'h0f, 8'hff, 8'h0f, 8'h60, 8'h20, 8'h10};

	// one expected latch write, in the order the block emits them
	typedef struct packed {
		dts_pkg::latch_t sel;
		logic [7:0]      value;
		logic            last;
		logic [15:0]     steps;
		logic            tvalid;
	} latch_wr_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                         cfg_we;
	logic [dts_pkg::CfgIdxW-1:0]  cfg_index;
	logic [dts_pkg::CfgDataW-1:0] cfg_data;

	dts_in_if  cmds_if();
	dts_out_if wr_if();

	dds_tuner_latch_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmds      (cmds_if),
		.writes    (wr_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the registers, latch shadows and
	// the tuned step count / tuned mark.
	// ------------------------------------------------------------------
	logic [dts_pkg::XtalW-1:0] xtal_q;
	logic [dts_pkg::PllW-1:0]  pll_q;
	logic [7:0]                shadow [4];
	logic [15:0]               steps_q;
	logic                      tuned_q;

	latch_wr_t cmd_writes[$];      // writes of the command being predicted
	latch_wr_t pending_writes[$];  // writes still owed by the block
	latch_wr_t want;

	// bookkeeping
	int err_cnt = 0;
	int n_cmd [4] = '{0, 0, 0, 0};
	int n_cfg = 0;
	int n_wr = 0;
	int n_prog = 0;
	int n_skip = 0;
	int n_pause = 0;
	int stuck = 0;

	// idling control: random stalls on both sides while this is set
	logic idle_on = 1'b1;
	int   stall_left = 0;

	task automatic flag_error(input string msg);
		err_cnt++;
		$display("%0t ERROR %s", $time, msg);
	endtask

	// masked write into a shadow byte; the full new byte goes out
	task automatic put_wr(input dts_pkg::latch_t sel, input logic [7:0] val,
			input logic [7:0] mask);
		latch_wr_t w;
		shadow[sel] = (shadow[sel] & ~mask) | (val & mask);
		w = '0;
		w.sel = sel;
		w.value = shadow[sel];
		cmd_writes.push_back(w);
	endtask

	// one DDS register write: data byte, then address with WRB high, address with
	// WRB low, and WRB back high
	task automatic dds_wr(input logic [7:0] addr, input logic [7:0] data);
		put_wr(dts_pkg::LATCH_DDS_DATA, data, dts_pkg::FullMask);
		put_wr(dts_pkg::LATCH_DDS_CTRL, dts_pkg::WrbBit | addr, dts_pkg::FullMask);
		put_wr(dts_pkg::LATCH_DDS_CTRL, addr, dts_pkg::FullMask);
		put_wr(dts_pkg::LATCH_DDS_CTRL, dts_pkg::WrbBit, dts_pkg::FullMask);
	endtask

	// Works out every latch write that one command causes and queues them.
	task automatic derive_latch_writes(input dts_pkg::cmd_t c,
			input logic [dts_pkg::FreqW-1:0] f_in, input logic sw);
		logic [dts_pkg::FreqW-1:0] f;
		int                        bidx;
		longint unsigned           den;
		longint unsigned           num;
		longint unsigned           q;
		longint unsigned           r;
		logic [15:0]               k;
		logic [20:0]               prod;
		cmd_writes.delete();
		case (c)
			dts_pkg::CMD_TUNE: begin
				f = (f_in > dts_pkg::FreqMax) ? dts_pkg::FreqMax : f_in;
				// band relay: edges inclusive, note the 3/2 swap in the middle bands
				if (f <= dts_pkg::BandEdge0) begin
					bidx = 0;
				end else if (f <= dts_pkg::BandEdge1) begin
					bidx = 1;
				end else if (f <= dts_pkg::BandEdge2) begin
					bidx = 3;
				end else if (f <= dts_pkg::BandEdge3) begin
					bidx = 2;
				end else if (f <= dts_pkg::BandEdge4) begin
					bidx = 4;
				end else begin
					bidx = 5;
				end
				put_wr(dts_pkg::LATCH_BAND, 8'h01 << bidx, dts_pkg::BandMask);
				// k = f*65536 / (xtal*pll), ties to even, saturating
				den = 64'(xtal_q) * 64'(pll_q);
				num = 64'(f) << 16;
				if (den == 0) begin
					k = dts_pkg::StepMax;
				end else begin
					q = num / den;
					r = num % den;
					if (2 * r > den || (2 * r == den && q[0])) begin
						q++;
					end
					k = (q > 64'd65535) ? dts_pkg::StepMax : q[15:0];
				end
				if (!tuned_q || k != steps_q) begin
					prod = 21'(k) * 21'(pll_q);
					dds_wr(dts_pkg::TuneBase, prod[15:8]);
					dds_wr(dts_pkg::TuneBase + 8'd1, prod[7:0]);
					dds_wr(dts_pkg::TuneBase + 8'd2, dts_pkg::DdsMid);
					for (int a = 7; a <= 9; a++) begin
						dds_wr(8'(a), 8'h00);
					end
					steps_q = k;
					tuned_q = 1'b1;
					n_prog++;
				end else begin
					n_skip++;
				end
			end
			dts_pkg::CMD_PTT: begin
				put_wr(dts_pkg::LATCH_BAND, sw ? dts_pkg::PttBit : 8'h00, dts_pkg::PttBit);
			end
			dts_pkg::CMD_PREAMP: begin
				put_wr(dts_pkg::LATCH_EXT, sw ? dts_pkg::PreampBit : 8'h00,
					dts_pkg::PreampBit);
			end
			default: begin
				// start-up sequence; tuned state survives it
				put_wr(dts_pkg::LATCH_BAND, 8'h00, dts_pkg::FullMask);
				put_wr(dts_pkg::LATCH_DDS_CTRL, 8'h00, dts_pkg::FullMask);
				put_wr(dts_pkg::LATCH_DDS_DATA, 8'h00, dts_pkg::FullMask);
				put_wr(dts_pkg::LATCH_EXT, 8'h00, dts_pkg::FullMask);
				put_wr(dts_pkg::LATCH_DDS_CTRL, dts_pkg::DdsResetBit | dts_pkg::WrbBit,
					dts_pkg::FullMask);
				put_wr(dts_pkg::LATCH_DDS_CTRL, dts_pkg::WrbBit, dts_pkg::FullMask);
				for (int i = 0; i < 7; i++) begin
					dds_wr(InitAddr[8*i +: 8], InitData[8*i +: 8]);
				end
			end
		endcase
		// tuned fields are those after the command, on every write of it
		foreach (cmd_writes[i]) begin
			cmd_writes[i].last = (i == cmd_writes.size() - 1);
			cmd_writes[i].steps = steps_q;
			cmd_writes[i].tvalid = tuned_q;
			pending_writes.push_back(cmd_writes[i]);
		end
	endtask

	// ------------------------------------------------------------------
	// Command side. send_cmd leaves valid high on return so that a
	// back-to-back item follows without a gap; quiet_cmds drops it.
	// ------------------------------------------------------------------
	task automatic send_cmd(input dts_pkg::cmd_t c, input logic [dts_pkg::FreqW-1:0] f,
			input logic sw);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			cmds_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		cmds_if.valid     <= 1'b1;
		cmds_if.cmd       <= c;
		cmds_if.freq_hz   <= f;
		cmds_if.switch_on <= sw;
		do @(posedge clk); while (!cmds_if.ready);
		derive_latch_writes(c, f, sw);
		n_cmd[c]++;
	endtask

	task automatic quiet_cmds();
		cmds_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// block is idle once the last write has gone; a few spare cycles on top
	task automatic drain();
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_put(input dts_pkg::cfg_idx_t idx,
			input logic [dts_pkg::CfgDataW-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	// writes both registers in random order; only called with the block idle
	task automatic set_config(input logic [dts_pkg::XtalW-1:0] x,
			input logic [dts_pkg::PllW-1:0] p);
		logic xtal_first;
		xtal_first = 1'($urandom_range(0, 1));
		if (xtal_first) begin
			cfg_put(dts_pkg::CFG_XTAL, x);
			cfg_put(dts_pkg::CFG_PLL, dts_pkg::CfgDataW'(p));
		end else begin
			cfg_put(dts_pkg::CFG_PLL, dts_pkg::CfgDataW'(p));
			cfg_put(dts_pkg::CFG_XTAL, x);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		xtal_q  = x;
		pll_q   = p;
		tuned_q = 1'b0;
		n_cfg++;
	endtask

	// ------------------------------------------------------------------
	// Latch-write side: random ready stalls in bursts.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left != 0) begin
			wr_if.ready <= 1'b0;
			stall_left  <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			wr_if.ready <= 1'b0;
			stall_left  <= $urandom_range(1, 15) - 1;
		end else begin
			wr_if.ready <= 1'b1;
		end
	end

	// Each accepted write is checked against the oldest outstanding one.
	always @(posedge clk) begin
		if (arst_n && wr_if.valid && wr_if.ready) begin
			n_wr++;
			if (pending_writes.size() == 0) begin
				flag_error($sformatf("unexpected write: latch %0d value %02h",
					wr_if.latch_select, wr_if.latch_value));
			end else begin
				want = pending_writes.pop_front();
				if (wr_if.latch_select !== want.sel) begin
					flag_error($sformatf("latch_select %0d, want %0d",
						wr_if.latch_select, want.sel));
				end
				if (wr_if.latch_value !== want.value) begin
					flag_error($sformatf("latch_value %02h, want %02h (latch %0d)",
						wr_if.latch_value, want.value, want.sel));
				end
				if (wr_if.last !== want.last) begin
					flag_error($sformatf("last %b, want %b", wr_if.last, want.last));
				end
				if (wr_if.tuned_steps !== want.steps) begin
					flag_error($sformatf("tuned_steps %0d, want %0d",
						wr_if.tuned_steps, want.steps));
				end
				if (wr_if.tuned_valid !== want.tvalid) begin
					flag_error($sformatf("tuned_valid %b, want %b",
						wr_if.tuned_valid, want.tvalid));
				end
			end
		end
	end

	// Watchdog: nothing moving on either channel for too long means a hang.
	always @(posedge clk) begin
		if (!arst_n || (cmds_if.valid && cmds_if.ready) || (wr_if.valid && wr_if.ready)) begin
			stuck <= 0;
		end else if (stuck >= StuckLimit) begin
			$display("%0t TIMEOUT: no item moved for %0d cycles, %0d writes outstanding",
				$time, stuck, pending_writes.size());
			$display("DONE: errors detected");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// start-up sequence from reset, then the two single-bit commands both ways
	task automatic test_startup_and_bits();
		send_cmd(dts_pkg::CMD_RESET, '0, 1'b0);
		send_cmd(dts_pkg::CMD_PREAMP, '0, 1'b1);
		send_cmd(dts_pkg::CMD_PTT, '0, 1'b1);
		send_cmd(dts_pkg::CMD_PREAMP, '1, 1'b0);
		send_cmd(dts_pkg::CMD_PTT, '1, 1'b0);
	endtask

	// every band edge and one past it, the clamp above 65 MHz, and a
	// config rewrite with the same values forcing a re-programme
	task automatic test_band_edges();
		send_cmd(dts_pkg::CMD_TUNE, '0, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge0, 1'b1);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge0 + 26'd1, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge1, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge1 + 26'd1, 1'b1);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge2, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge2 + 26'd1, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge3, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge3 + 26'd1, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge4, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::BandEdge4 + 26'd1, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::FreqMax, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, dts_pkg::FreqMax + 26'd1, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, '1, 1'b0);
		quiet_cmds();
		drain();
		// same register values, but the write alone drops the tuned mark
		set_config(dts_pkg::XtalReset, dts_pkg::PllReset);
		send_cmd(dts_pkg::CMD_TUNE, '1, 1'b0);
	endtask

	// exact halves: 2^28 Hz reference gives k = f/4096, so f = 4096n + 2048
	// is a tie; even n stays, odd n rounds up
	task automatic test_rounding();
		quiet_cmds();
		drain();
		set_config(29'h1000_0000, 5'd1);
		send_cmd(dts_pkg::CMD_TUNE, 26'd4098048, 1'b0);
		send_cmd(dts_pkg::CMD_TUNE, 26'd4102144, 1'b0);
	endtask

	// zero multiplier, then zero reference: the step count pins at full scale;
	// the start-up sequence afterwards keeps the tuned state
	task automatic test_zero_divisor();
		quiet_cmds();
		drain();
		set_config(dts_pkg::XtalReset, 5'd0);
		send_cmd(dts_pkg::CMD_TUNE, 26'd10000000, 1'b0);
		quiet_cmds();
		drain();
		set_config('0, 5'd1);
		send_cmd(dts_pkg::CMD_TUNE, 26'd1, 1'b0);
		send_cmd(dts_pkg::CMD_RESET, '0, 1'b1);
	endtask

	// eight register settings, extremes among them, each with a random mix;
	// tunes favour repeats and near-repeats so the skip path gets exercised
	task automatic test_random();
		logic [dts_pkg::XtalW-1:0] x;
		logic [dts_pkg::PllW-1:0]  p;
		logic [dts_pkg::FreqW-1:0] f;
		logic [dts_pkg::FreqW-1:0] last_f;
		dts_pkg::cmd_t             c;
		int                        pick;
		last_f = 26'd7100000;
		for (int ph = 0; ph < 8; ph++) begin
			quiet_cmds();
			drain();
			case (ph)
				0: begin
					x = 29'd1000000;
					p = 5'd1;
				end
				1: begin
					x = 29'd400000000;
					p = 5'd20;
				end
				2: begin
					x = dts_pkg::XtalReset;
					p = dts_pkg::PllReset;
				end
				3: begin
					x = '1;
					p = '1;
				end
				7: begin
					x = dts_pkg::XtalW'($urandom());
					p = dts_pkg::PllW'($urandom_range(1, 31));
				end
				default: begin
					x = dts_pkg::XtalW'($urandom_range(1000000, 400000000));
					p = dts_pkg::PllW'($urandom_range(1, 20));
				end
			endcase
			set_config(x, p);
			// one calm stretch mid-run, and the closing phase without stalls
			idle_on = (ph != 2 && ph != 7);
			for (int i = 0; i < 57; i++) begin
				// now and then hold the next command until all writes are out
				if ($urandom_range(0, 29) == 0) begin
					quiet_cmds();
					drain();
					n_pause++;
				end
				pick = $urandom_range(0, 19);
				if (pick <= 10) begin
					c = dts_pkg::CMD_TUNE;
				end else if (pick <= 13) begin
					c = dts_pkg::CMD_PTT;
				end else if (pick <= 16) begin
					c = dts_pkg::CMD_PREAMP;
				end else begin
					c = dts_pkg::CMD_RESET;
				end
				case ($urandom_range(0, 9))
					0, 1: f = last_f;
					2: f = last_f + dts_pkg::FreqW'($urandom_range(0, 2000));
					3: begin
						case ($urandom_range(0, 4))
							0: f = dts_pkg::BandEdge0;
							1: f = dts_pkg::BandEdge1;
							2: f = dts_pkg::BandEdge2;
							3: f = dts_pkg::BandEdge3;
							default: f = dts_pkg::BandEdge4;
						endcase
						f = f + dts_pkg::FreqW'($urandom_range(0, 2)) - 26'd1;
					end
					4: f = dts_pkg::FreqW'($urandom_range(65000000, 67108863));
					5: f = dts_pkg::FreqW'($urandom_range(0, 1000000));
					default: f = dts_pkg::FreqW'($urandom_range(0, 65000000));
				endcase
				if (c == dts_pkg::CMD_TUNE) begin
					last_f = f;
				end
				send_cmd(c, f, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n            <= 1'b0;
		cmds_if.valid     <= 1'b0;
		cmds_if.cmd       <= dts_pkg::CMD_TUNE;
		cmds_if.freq_hz   <= '0;
		cmds_if.switch_on <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= dts_pkg::CFG_XTAL;
		cfg_data          <= '0;

		// predictor state matches the block after reset
		xtal_q  = dts_pkg::XtalReset;
		pll_q   = dts_pkg::PllReset;
		steps_q = '0;
		tuned_q = 1'b0;
		foreach (shadow[i]) begin
			shadow[i] = 8'h00;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_startup_and_bits();
		test_band_edges();
		test_rounding();
		test_zero_divisor();
		test_random();

		// all items are in; let the last writes come out, then a short tail
		// to catch anything extra
		quiet_cmds();
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_writes.size() != 0) begin
			flag_error($sformatf("%0d writes never arrived", pending_writes.size()));
		end

		$display("Covered %0d tune, %0d PTT, %0d preamp, %0d start-up commands over %0d settings,",
			n_cmd[dts_pkg::CMD_TUNE], n_cmd[dts_pkg::CMD_PTT], n_cmd[dts_pkg::CMD_PREAMP],
			n_cmd[dts_pkg::CMD_RESET], n_cfg);
		$display("%0d writes checked; DDS programmed %0d times, unchanged %0d; %0d drains; %0d errors",
			n_wr, n_prog, n_skip, n_pause, err_cnt);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
